// ===== src/multiset_intersection_engine_top_macros.svh =====
// ----------------------------------------------------------------------------
// Multiset intersection engine assertion macros
// Concurrent assertion helpers shared by the engine's top level.
// ----------------------------------------------------------------------------
`ifndef MULTISET_INTERSECTION_ENGINE_TOP_MACROS_SVH
`define MULTISET_INTERSECTION_ENGINE_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define MIE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define MIE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define MIE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)

`define MIE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== src/mie_pkg.sv =====
// ----------------------------------------------------------------------------
// Multiset intersection engine package
// Sizes, codes, table entry type, control interface types and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mie_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int COUNT_WIDTH = 16;
   localparam int VALUE_WIDTH = 32;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int POS_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

   typedef enum logic [1:0] {
      OP_LOAD_A = 2'd0,
      OP_LOAD_B = 2'd1,
      OP_DRAIN  = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      RS_ACCEPTED = 2'd0,
      RS_FULL     = 2'd1,
      RS_GIVEN    = 2'd2,
      RS_EMPTY    = 2'd3
   } rsp_status_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] key;
      logic [COUNT_WIDTH-1:0] cnt_b;
      logic [COUNT_WIDTH-1:0] cnt_a;
   } entry_type;

   typedef struct packed {
      logic           accept;
      logic           scan_init;
      logic           scan_from_cursor;
      logic           scan_next;
      logic           rd_en;
      logic           rd_cursor;
      logic           insert;
      logic           upd_a;
      logic           upd_b;
      logic           cur_adv;
      logic           emit;
      logic           clear;
      logic           res_set;
      rsp_status_type res_status;
      logic           res_last;
      logic           out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      op_type op;
      logic   scan_end;
      logic   match;
      logic   cursor_end;
      logic   drained;
      logic   more;
      logic   tail_hit;
      logic   full;
      logic   out_free;
   } ctrl_stat_type;

   function automatic logic [VALUE_WIDTH-1:0] make_key(input logic [31:0] v);
      logic signed [63:0] wide;
      wide = 64'(signed'(v));
      return wide[VALUE_WIDTH-1:0];
   endfunction

   function automatic logic [31:0] key_to_value(input logic [VALUE_WIDTH-1:0] k);
      logic signed [63:0] wide;
      wide = 64'(signed'(k));
      return wide[31:0];
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
      return (c == CNT_MAX) ? c : c + 1'b1;
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] overlap(input entry_type e);
      return (e.cnt_a < e.cnt_b) ? e.cnt_a : e.cnt_b;
   endfunction

endpackage

// ===== src/mie_ctrl.sv =====
// ----------------------------------------------------------------------------
// Multiset intersection engine controller
// Sequences key searches, drain steps, table clears and result hand-off for one beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mie_ctrl
   import mie_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  ctrl_stat_type stat,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_START    = 9'b000000010,
      S_LOOK_RD  = 9'b000000100,
      S_LOOK_CHK = 9'b000001000,
      S_SEEK_RD  = 9'b000010000,
      S_SEEK_CHK = 9'b000100000,
      S_TAIL_RD  = 9'b001000000,
      S_TAIL_CHK = 9'b010000000,
      S_FINISH   = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_START;
            end
         end
         S_START: begin
            unique case (stat.op)
               OP_LOAD_A, OP_LOAD_B: begin
                  cmd.scan_init = 1'b1;
                  state_in      = S_LOOK_RD;
               end
               OP_DRAIN: begin
                  state_in = S_SEEK_RD;
               end
               OP_CLEAR: begin
                  cmd.clear      = 1'b1;
                  cmd.res_set    = 1'b1;
                  cmd.res_status = RS_ACCEPTED;
                  state_in       = S_FINISH;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_LOOK_RD: begin
            if (stat.scan_end) begin
               cmd.res_set = 1'b1;
               if (stat.op == OP_LOAD_A && stat.full) begin
                  cmd.res_status = RS_FULL;
               end else begin
                  cmd.res_status = RS_ACCEPTED;
                  cmd.insert     = (stat.op == OP_LOAD_A);
               end
               state_in = S_FINISH;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_LOOK_CHK;
            end
         end
         S_LOOK_CHK: begin
            if (stat.match) begin
               cmd.upd_a      = (stat.op == OP_LOAD_A);
               cmd.upd_b      = (stat.op == OP_LOAD_B);
               cmd.res_set    = 1'b1;
               cmd.res_status = RS_ACCEPTED;
               state_in       = S_FINISH;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_LOOK_RD;
            end
         end
         S_SEEK_RD: begin
            if (stat.cursor_end) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = RS_EMPTY;
               state_in       = S_FINISH;
            end else begin
               cmd.rd_en     = 1'b1;
               cmd.rd_cursor = 1'b1;
               state_in      = S_SEEK_CHK;
            end
         end
         S_SEEK_CHK: begin
            if (stat.drained) begin
               cmd.cur_adv = 1'b1;
               state_in    = S_SEEK_RD;
            end else begin
               cmd.emit       = 1'b1;
               cmd.res_set    = 1'b1;
               cmd.res_status = RS_GIVEN;
               if (stat.more) begin
                  cmd.res_last = 1'b0;
                  state_in     = S_FINISH;
               end else begin
                  cmd.res_last         = 1'b1;
                  cmd.scan_from_cursor = 1'b1;
                  state_in             = S_TAIL_RD;
               end
            end
         end
         S_TAIL_RD: begin
            if (stat.scan_end) begin
               state_in = S_FINISH;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_TAIL_CHK;
            end
         end
         S_TAIL_CHK: begin
            if (stat.tail_hit) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = RS_GIVEN;
               cmd.res_last   = 1'b0;
               state_in       = S_FINISH;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_TAIL_RD;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/mie_datapath.sv =====
// ----------------------------------------------------------------------------
// Multiset intersection engine datapath
// Key table memory, table pointers, drain position and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mie_datapath
   import mie_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [1:0]    req_tuser,
   input  logic [31:0]   req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata,
   output logic [1:0]    rsp_tuser,
   output logic          rsp_tlast,
   input  ctrl_cmd_type  cmd,
   output ctrl_stat_type stat
);

   entry_type              entry_mem_ff [TABLE_DEPTH];
   entry_type              rd_ff;

   op_type                 op_ff;
   logic [VALUE_WIDTH-1:0] key_ff;
   logic [POS_W-1:0]       used_ff;
   logic [POS_W-1:0]       used_in;
   logic [POS_W-1:0]       cursor_ff;
   logic [POS_W-1:0]       cursor_in;
   logic [POS_W-1:0]       scan_ff;
   logic [POS_W-1:0]       scan_in;
   logic [COUNT_WIDTH-1:0] emitted_ff;
   logic [COUNT_WIDTH-1:0] emitted_in;

   logic [31:0]            res_value_ff;
   logic [31:0]            res_value_in;
   rsp_status_type         res_status_ff;
   logic                   res_last_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [31:0]            rsp_value_ff;
   rsp_status_type         rsp_status_ff;
   logic                   rsp_last_ff;

   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   entry_type              wr_data;
   logic [COUNT_WIDTH-1:0] rd_overlap;

   assign rd_overlap = overlap(rd_ff);

   always_comb begin
      stat.op         = op_ff;
      stat.scan_end   = (scan_ff >= used_ff);
      stat.match      = (rd_ff.key == key_ff);
      stat.cursor_end = (cursor_ff >= used_ff);
      stat.drained    = (emitted_ff >= rd_overlap);
      stat.more       = (sat_inc(emitted_ff) < rd_overlap);
      stat.tail_hit   = (rd_overlap != '0);
      stat.full       = (used_ff == POS_W'(TABLE_DEPTH));
      stat.out_free   = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      rd_addr = cmd.rd_cursor ? cursor_ff[IDX_W-1:0] : scan_ff[IDX_W-1:0];
      wr_en   = cmd.insert || cmd.upd_a || cmd.upd_b;
      wr_addr = cmd.insert ? used_ff[IDX_W-1:0] : scan_ff[IDX_W-1:0];
      wr_data = rd_ff;
      if (cmd.insert) begin
         wr_data.key   = key_ff;
         wr_data.cnt_a = COUNT_WIDTH'(1);
         wr_data.cnt_b = '0;
      end else if (cmd.upd_a) begin
         wr_data.cnt_a = sat_inc(rd_ff.cnt_a);
      end else begin
         wr_data.cnt_b = sat_inc(rd_ff.cnt_b);
      end
   end

   always_comb begin
      scan_in = scan_ff;
      if (cmd.scan_init) begin
         scan_in = '0;
      end else if (cmd.scan_from_cursor) begin
         scan_in = cursor_ff + 1'b1;
      end else if (cmd.scan_next) begin
         scan_in = scan_ff + 1'b1;
      end

      used_in = used_ff;
      if (cmd.clear) begin
         used_in = '0;
      end else if (cmd.insert) begin
         used_in = used_ff + 1'b1;
      end

      cursor_in  = cursor_ff;
      emitted_in = emitted_ff;
      if (cmd.clear) begin
         cursor_in  = '0;
         emitted_in = '0;
      end else if (cmd.cur_adv) begin
         cursor_in  = cursor_ff + 1'b1;
         emitted_in = '0;
      end else if (cmd.emit) begin
         emitted_in = sat_inc(emitted_ff);
      end

      res_value_in = res_value_ff;
      if (cmd.emit) begin
         res_value_in = key_to_value(rd_ff.key);
      end else if (cmd.res_set && cmd.res_status != RS_GIVEN) begin
         res_value_in = '0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         cursor_ff    <= '0;
         emitted_ff   <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         cursor_ff    <= cursor_in;
         emitted_ff   <= emitted_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= op_type'(req_tuser);
         key_ff <= make_key(req_tdata);
      end
      res_value_ff <= res_value_in;
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_status;
         res_last_ff   <= cmd.res_last;
      end
      if (cmd.out_load) begin
         rsp_value_ff  <= res_value_ff;
         rsp_status_ff <= res_status_ff;
         rsp_last_ff   <= res_last_ff && (res_status_ff == RS_GIVEN);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_ff <= entry_mem_ff[rd_addr];
      end
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== src/multiset_intersection_engine_top.sv =====
// Steps from the accepting edge to rsp_tvalid: a clear passes start and finish; a load
// reads and checks each key in turn until a match or the table's end; a drain reads and
// steps over spent entries, then for a given element that uses up its entry checks later
// entries for the last mark. One beat is in work at a time: every compare waits on the
// table's single registered read port, and the result waits until the output is free.
// Reset (synchronous, active high) empties the table and the drain position.
// ----------------------------------------------------------------------------
// Multiset intersection engine top level
// Counts keys of two multisets and drains their intersection in load order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multiset_intersection_engine_top_macros.svh"

module multiset_intersection_engine_top
   import mie_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] element_value
   input  logic [1:0]  req_tuser,  // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [31:0] result_value
   output logic [1:0]  rsp_tuser,  // [1:0] status
   output logic        rsp_tlast
);

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   mie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mie_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .stat       (stat)
   );

   `MIE_ASSERT_SAME(a_plain_rsp, clock, reset, rsp_tvalid && (rsp_tuser != RS_GIVEN), (rsp_tdata == '0) && !rsp_tlast, "Non-drain beat carries data or last.")
   `MIE_ASSERT_NEXT(a_one_beat, clock, reset, req_tvalid && req_tready, !req_tready, "Second beat taken while one is in work.")
   `MIE_ASSERT_SAME(a_load_free, clock, reset, cmd.out_load, stat.out_free, "Result loaded over an untaken result.")
   `MIE_ASSERT_SAME(a_insert_room, clock, reset, cmd.insert, !stat.full, "Key inserted into a full table.")

endmodule

// ===== verif/multiset_intersection_engine_top_tb.sv =====
// ----------------------------------------------------------------------------
// Multiset intersection engine testbench
// Drives load, drain and clear beats into the engine with random gaps on both
// stream ports. Each accepted beat is run through a local copy of the key
// table to predict its answer, and each answer beat is compared against the
// prediction or the answer a directed row gives. A short directed table
// comes first, then random rounds of well-formed load/drain runs with noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multiset_intersection_engine_top_tb;
   import mie_pkg::*;

   typedef struct packed {
      logic [31:0]    value;
      rsp_status_type status;
      logic           last;
   } answer_type;

   typedef struct {
      op_type      op;
      logic [31:0] value;
      bit          typed;
      answer_type  ans;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   logic [VALUE_WIDTH-1:0] tbl_key   [TABLE_DEPTH];
   logic [COUNT_WIDTH-1:0] tbl_cnt_a [TABLE_DEPTH];
   logic [COUNT_WIDTH-1:0] tbl_cnt_b [TABLE_DEPTH];
   int                     tbl_used = 0;
   int                     drain_pos = 0;
   logic [COUNT_WIDTH-1:0] drain_given = '0;

   answer_type   pending_answers [$];
   stim_row_type stim_rows [$];
   int           gap_max = 3;
   int           beats_sent = 0;
   int           fails = 0;

   multiset_intersection_engine_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   function automatic logic [COUNT_WIDTH-1:0] count_up(input logic [COUNT_WIDTH-1:0] c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] pair_count(input int i);
      return (tbl_cnt_a[i] < tbl_cnt_b[i]) ? tbl_cnt_a[i] : tbl_cnt_b[i];
   endfunction

   function automatic answer_type compute_answer(input op_type op, input logic [31:0] v);
      answer_type             a;
      int                     hit;
      logic [VALUE_WIDTH-1:0] k;
      a.value = '0;
      a.status = RS_ACCEPTED;
      a.last = 1'b0;
      k = v[VALUE_WIDTH-1:0];
      hit = -1;
      for (int i = 0; i < tbl_used; i++) begin
         if (hit < 0 && tbl_key[i] == k) hit = i;
      end
      case (op)
         OP_LOAD_A: begin
            if (hit >= 0) begin
               tbl_cnt_a[hit] = count_up(tbl_cnt_a[hit]);
            end else if (tbl_used < TABLE_DEPTH) begin
               tbl_key[tbl_used] = k;
               tbl_cnt_a[tbl_used] = COUNT_WIDTH'(1);
               tbl_cnt_b[tbl_used] = '0;
               tbl_used++;
            end else begin
               a.status = RS_FULL;
            end
         end
         OP_LOAD_B: begin
            if (hit >= 0) tbl_cnt_b[hit] = count_up(tbl_cnt_b[hit]);
         end
         OP_DRAIN: begin
            while (drain_pos < tbl_used && drain_given >= pair_count(drain_pos)) begin
               drain_pos++;
               drain_given = '0;
            end
            if (drain_pos >= tbl_used) begin
               a.status = RS_EMPTY;
            end else begin
               a.status = RS_GIVEN;
               a.value = 32'(signed'(tbl_key[drain_pos]));
               drain_given = count_up(drain_given);
               a.last = (drain_given >= pair_count(drain_pos));
               for (int j = drain_pos + 1; j < tbl_used; j++) begin
                  if (pair_count(j) != 0) a.last = 1'b0;
               end
            end
         end
         default: begin
            tbl_used = 0;
            drain_pos = 0;
            drain_given = '0;
         end
      endcase
      return a;
   endfunction

   function automatic answer_type reply(input logic [31:0] v, input rsp_status_type s,
                                        input logic l);
      answer_type a;
      a.value = v;
      a.status = s;
      a.last = l;
      return a;
   endfunction

   function automatic void add_row(input op_type op, input logic [31:0] v,
                                   input bit typed = 1'b0, input answer_type ans = '0);
      stim_row_type r;
      r.op = op;
      r.value = v;
      r.typed = typed;
      r.ans = ans;
      stim_rows = {stim_rows, r};
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 15))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_beat(input op_type op, input logic [31:0] v,
                            input bit typed = 1'b0, input answer_type ans = '0);
      int         gap;
      answer_type predicted;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= v;
      do @(posedge clock); while (!req_tready);
      predicted = compute_answer(op, v);
      pending_answers = {pending_answers, (typed ? ans : predicted)};
      beats_sent++;
   endtask

   task automatic hold_until_answered();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   initial begin
      int         stall;
      answer_type got;
      answer_type want;
      wait (reset == 1'b0);
      forever begin
         stall = $urandom_range(0, gap_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got = reply(rsp_tdata, rsp_status_type'(rsp_tuser), rsp_tlast);
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected beat, actual value=%h status=%0d last=%b",
                     $time, got.value, got.status, got.last);
            fails++;
         end else begin
            want = pending_answers.pop_front();
            if (got.value !== want.value) begin
               $display("%0t: result_value expected %h actual %h",
                        $time, want.value, got.value);
               fails++;
            end
            if (got.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, got.status);
               fails++;
            end
            if (got.last !== want.last) begin
               $display("%0t: last_flag expected %b actual %b",
                        $time, want.last, got.last);
               fails++;
            end
         end
      end
   end

   initial begin
      #100_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      logic [31:0] pool [$];
      int          n;
      int          a_next;
      int          steps;
      int          drains;
      int          guard;
      bit          full_round;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      add_row(OP_DRAIN,  32'h0000_0000, 1'b1, reply(32'h0, RS_EMPTY, 1'b0));
      add_row(OP_LOAD_B, 32'h0000_0005, 1'b1, reply(32'h0, RS_ACCEPTED, 1'b0));
      add_row(OP_LOAD_A, 32'h8000_0000, 1'b1, reply(32'h0, RS_ACCEPTED, 1'b0));
      add_row(OP_LOAD_A, 32'h7FFF_FFFF, 1'b1, reply(32'h0, RS_ACCEPTED, 1'b0));
      add_row(OP_LOAD_A, 32'hFFFF_FFFF, 1'b1, reply(32'h0, RS_ACCEPTED, 1'b0));
      add_row(OP_LOAD_A, 32'h0000_0000, 1'b1, reply(32'h0, RS_ACCEPTED, 1'b0));
      add_row(OP_LOAD_A, 32'h7FFF_FFFF, 1'b1, reply(32'h0, RS_ACCEPTED, 1'b0));
      add_row(OP_LOAD_B, 32'h7FFF_FFFF);
      add_row(OP_LOAD_B, 32'h8000_0000);
      add_row(OP_LOAD_B, 32'h7FFF_FFFF);
      add_row(OP_LOAD_B, 32'h1234_5678, 1'b1, reply(32'h0, RS_ACCEPTED, 1'b0));
      add_row(OP_DRAIN,  32'hFFFF_FFFF, 1'b1, reply(32'h8000_0000, RS_GIVEN, 1'b0));
      add_row(OP_LOAD_B, 32'h8000_0000);
      add_row(OP_DRAIN,  32'h0000_0000);
      add_row(OP_LOAD_B, 32'h0000_0000);
      add_row(OP_DRAIN,  32'h5A5A_5A5A);
      add_row(OP_DRAIN,  32'h0000_0000);
      add_row(OP_DRAIN,  32'h0000_0000, 1'b1, reply(32'h0, RS_EMPTY, 1'b0));
      add_row(OP_LOAD_A, 32'hFFFF_FFFF);
      add_row(OP_LOAD_B, 32'hFFFF_FFFF);
      add_row(OP_DRAIN,  32'h0000_0000);
      add_row(OP_CLEAR,  32'hA5A5_A5A5, 1'b1, reply(32'h0, RS_ACCEPTED, 1'b0));
      add_row(OP_DRAIN,  32'h0000_0000, 1'b1, reply(32'h0, RS_EMPTY, 1'b0));

      foreach (stim_rows[i]) begin
         send_beat(stim_rows[i].op, stim_rows[i].value, stim_rows[i].typed, stim_rows[i].ans);
      end
      hold_until_answered();

      while (beats_sent < 1150) begin
         gap_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
         if ($urandom_range(0, 3) == 0) hold_until_answered();
         full_round = ($urandom_range(0, 11) == 0);
         n = full_round ? 90 : $urandom_range(1, 8);
         pool.delete();
         repeat (n) pool = {pool, pick_value()};
         steps = full_round ? 2 * n + 10 : $urandom_range(n, 4 * n);
         a_next = 0;
         repeat (steps) begin
            if ($urandom_range(0, 11) == 0) begin
               send_beat(op_type'($urandom_range(0, 3)), pick_value());
            end else if ($urandom_range(0, 99) < 55) begin
               if (a_next < n) begin
                  send_beat(OP_LOAD_A, pool[a_next]);
                  a_next++;
               end else begin
                  send_beat(OP_LOAD_A, pool[$urandom_range(0, n - 1)]);
               end
            end else if ($urandom_range(0, 5) == 0) begin
               send_beat(OP_LOAD_B, pick_value());
            end else begin
               send_beat(OP_LOAD_B, pool[$urandom_range(0, n - 1)]);
            end
         end
         drains = full_round ? $urandom_range(5, 40) : $urandom_range(1, 3 * n + 3);
         repeat (drains) begin
            if ($urandom_range(0, 5) == 0) begin
               send_beat($urandom_range(0, 1) ? OP_LOAD_A : OP_LOAD_B,
                         pool[$urandom_range(0, n - 1)]);
            end
            send_beat(OP_DRAIN, $urandom);
         end
         if ($urandom_range(0, 3) != 0) send_beat(OP_CLEAR, $urandom);
      end

      req_tvalid <= 1'b0;
      guard = 0;
      while (pending_answers.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (300) @(posedge clock);
      if (pending_answers.size() != 0) begin
         $display("%0t: %0d expected beats never arrived", $time, pending_answers.size());
         fails++;
      end
      if (fails == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/mie_pkg.sv
src/mie_ctrl.sv
src/mie_datapath.sv
src/multiset_intersection_engine_top.sv
verif/multiset_intersection_engine_top_tb.sv
